[rtl/core/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ccsc_pkg.sv]
// types, mode codes and case folding functions of the caseless compare unit
`timescale 1ns / 1ps

package ccsc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] mode_t;

	localparam mode_t MODE_ASCII = 2'd0;
	localparam mode_t MODE_866   = 2'd1;
	localparam mode_t MODE_1251  = 2'd2;
	localparam mode_t MODE_125X  = 2'd3;

	localparam byte_t CH_X_866    = 8'd229;
	localparam byte_t CH_X_LOWER  = 8'h78;
	localparam byte_t CH_BLOCK_866 = 8'd149;
	localparam byte_t CH_IO_1251  = 8'hA8;
	localparam byte_t CH_MUL_125X = 8'hD7;
	localparam byte_t CH_DIV_125X = 8'hF7;

	// ascii upper to lower
	function automatic byte_t fold_ascii(input byte_t c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	// code page 866 cyrillic fold
	function automatic byte_t fold_866(input byte_t c);
		if (c >= 8'd128 && c <= 8'd159) begin
			return c | 8'h20;
		end
		if (c >= 8'd224 && c <= 8'd239) begin
			return c - 8'd48;
		end
		if (c == 8'd240) begin
			return 8'd241;
		end
		return c;
	endfunction

	// code page 1251 cyrillic fold
	function automatic byte_t fold_1251(input byte_t c);
		byte_t r;
		r = c;
		if (r >= 8'hC0 && r <= 8'hDF) begin
			r = r | 8'h20;
		end
		if (r == CH_IO_1251) begin
			r = r + 8'd16;
		end
		return r;
	endfunction

	// code pages 1250/1252 latin fold
	function automatic byte_t fold_125x(input byte_t c);
		if (c >= 8'hC0 && c <= 8'hDE) begin
			return c | 8'h20;
		end
		return c;
	endfunction

	// one nonzero pair: 1 when it matches after folding
	function automatic logic pair_match(input byte_t a, input byte_t b, input mode_t mode);
		byte_t fa;
		byte_t fb;
		if (a == b) begin
			return 1'b1;
		end
		fa = a;
		fb = b;
		if (mode == MODE_866) begin
			if (fa == CH_X_866) fa = CH_X_LOWER;
			if (fb == CH_X_866) fb = CH_X_LOWER;
		end
		fa = fold_ascii(fa);
		fb = fold_ascii(fb);
		if (fa == fb) begin
			return 1'b1;
		end
		if (!fa[7] || !fb[7]) begin
			return 1'b0;
		end
		unique case (mode)
			MODE_866: begin
				if (fa != CH_BLOCK_866 && fb != CH_BLOCK_866) begin
					fa = fold_866(fa);
					fb = fold_866(fb);
				end
			end
			MODE_1251: begin
				fa = fold_1251(fa);
				fb = fold_1251(fb);
			end
			MODE_125X: begin
				if (fa != CH_MUL_125X && fa != CH_DIV_125X &&
					fb != CH_MUL_125X && fb != CH_DIV_125X) begin
					fa = fold_125x(fa);
					fb = fold_125x(fb);
				end
			end
			default: begin
			end
		endcase
		return fa == fb;
	endfunction

endpackage

[rtl/core/codepage_caseless_string_compare_unit.sv]
// top level of the code page aware caseless string compare unit
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | to unit   | in_valid / in_ready  | char_a, char_b, first_pair
//  out     | from unit | out_valid / out_ready| strings_equal
//  cfg     | to unit   | cfg_valid / cfg_ready| code_page_mode
//
// one character pair per cycle unless a verdict stalls; folding and compare
// run in the input register; the verdict is registered as the pair leaves
// a stalled verdict holds the pair behind it; pairs that give no verdict
// keep flowing, so input only stops when a second verdict is waiting
// reset sets mode to ascii, empties both registers, starts a fresh comparison
`timescale 1ns / 1ps
`include "assert_macros.svh"

module codepage_caseless_string_compare_unit import ccsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_a,
	input  logic [7:0] char_b,
	input  logic       first_pair,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       strings_equal,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] code_page_mode
);

	mode_t mode_q;
	logic  decided_q;
	logic  v_s1;
	byte_t a_s1;
	byte_t b_s1;
	logic  first_s1;
	logic  out_valid_q;
	logic  eq_q;

	logic  dec_eff;
	logic  emit_s1;
	logic  eq_s1;
	logic  adv_s1;
	logic  a_zero;
	logic  b_zero;

	// mode register, written at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ASCII;
		end else if (cfg_valid) begin
			mode_q <= code_page_mode;
		end
	end

	// fold, compare and decide for the pair in the input register
	always_comb begin
		a_zero  = (a_s1 == 8'd0);
		b_zero  = (b_s1 == 8'd0);
		dec_eff = decided_q & ~first_s1;
		eq_s1   = a_zero & b_zero;
		if (a_zero || b_zero) begin
			emit_s1 = 1'b1;
		end else begin
			emit_s1 = ~pair_match(a_s1, b_s1, mode_q);
		end
		emit_s1 = emit_s1 & ~dec_eff;
	end

	// the pair leaves when its verdict, if any, has room
	assign adv_s1   = v_s1 & (~emit_s1 | ~out_valid_q | out_ready);
	assign in_ready = ~v_s1 | adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_s1     <= char_a;
			b_s1     <= char_b;
			first_s1 <= first_pair;
		end
	end

	// comparison state, updated as each pair retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decided_q <= 1'b0;
		end else if (adv_s1) begin
			decided_q <= dec_eff | emit_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			eq_q <= eq_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign strings_equal = eq_q;

	// checks
	`ASSERT_NEXT(a_verdict_sets_decided, adv_s1 && emit_s1, decided_q && out_valid_q,
		"verdict transfer did not mark comparison decided")
	`ASSERT_NEXT(a_first_clears_decided, adv_s1 && first_s1 && !emit_s1, !decided_q,
		"first pair did not restart the comparison")
	`ASSERT_SAME(a_no_emit_when_decided, v_s1 && decided_q && !first_s1, !emit_s1,
		"verdict produced after comparison was decided")
	`ASSERT_NEXT(a_blocked_pair_holds, v_s1 && emit_s1 && out_valid_q && !out_ready,
		v_s1 && $stable(a_s1) && $stable(b_s1),
		"pair behind a stalled verdict was lost")

endmodule
